/* rtl/core/pal_pkg.sv */
// shared types, codes and defaults for the positional array list
package pal_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int ELEM_W_DEF   = 32;

    localparam int REQ_W = 3;
    localparam int POS_W = 7;
    localparam int VAL_W = 32;
    localparam int STS_W = 2;
    localparam int CNT_W = 7;

    typedef enum logic [REQ_W-1:0] {
        REQ_CLEAR   = 3'd0,
        REQ_INSERT  = 3'd1,
        REQ_DEL_POS = 3'd2,
        REQ_SEARCH  = 3'd3,
        REQ_DEL_VAL = 3'd4
    } t_req_type;

    typedef enum logic [STS_W-1:0] {
        STS_DONE      = 2'd0,
        STS_BAD_POS   = 2'd1,
        STS_FULL      = 2'd2,
        STS_NOT_FOUND = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_TAG,
        S_GATHER,
        S_APPLY
    } t_state;

    typedef enum logic [2:0] {
        CO_HOLD,
        CO_TAG_POS,
        CO_TAG_VAL,
        CO_GATHER,
        CO_INSERT,
        CO_REMOVE
    } t_cell_op;

endpackage

/* rtl/core/pal_if.sv */
// request and result channel interfaces of the positional array list
interface pal_in_if;
    logic                          valid;
    logic                          ready;
    logic [pal_pkg::REQ_W-1:0]     req_type;
    logic [pal_pkg::POS_W-1:0]     position;
    logic signed [pal_pkg::VAL_W-1:0] value;

    modport source (output valid, output req_type, output position, output value,
                    input ready);
    modport sink   (input valid, input req_type, input position, input value,
                    output ready);
endinterface

interface pal_out_if;
    logic                          valid;
    logic                          ready;
    logic [pal_pkg::STS_W-1:0]     status;
    logic signed [pal_pkg::VAL_W-1:0] removed_value;
    logic [pal_pkg::POS_W-1:0]     found_position;
    logic [pal_pkg::CNT_W-1:0]     entry_count;

    modport source (output valid, output status, output removed_value,
                    output found_position, output entry_count, input ready);
    modport sink   (input valid, input status, input removed_value,
                    input found_position, input entry_count, output ready);
endinterface

/* rtl/core/pal_cell.sv */
// one list cell: holds an entry, shifts with its neighbors, joins the match gather
module pal_cell #(
    parameter int CAPACITY      = pal_pkg::CAPACITY_DEF,
    parameter int ELEMENT_WIDTH = pal_pkg::ELEM_W_DEF,
    parameter int CELL_IDX      = 0
) (
    input  logic                      i_clk,
    input  pal_pkg::t_cell_op         i_op,
    input  logic [ELEMENT_WIDTH-1:0]  i_key,
    input  logic [$clog2(CAPACITY+1) > pal_pkg::POS_W ?
                  $clog2(CAPACITY+1) : pal_pkg::POS_W:0] i_sel,
    input  logic [$clog2(CAPACITY+1) > pal_pkg::POS_W ?
                  $clog2(CAPACITY+1) : pal_pkg::POS_W:0] i_count,
    input  logic [ELEMENT_WIDTH-1:0]  i_prev,
    input  logic [ELEMENT_WIDTH-1:0]  i_next,
    input  logic                      i_far_hit,
    input  logic [ELEMENT_WIDTH-1:0]  i_far_val,
    input  logic [$clog2(CAPACITY)-1:0] i_far_idx,
    output logic [ELEMENT_WIDTH-1:0]  o_elem,
    output logic                      o_hit,
    output logic [ELEMENT_WIDTH-1:0]  o_val,
    output logic [$clog2(CAPACITY)-1:0] o_idx
);
    localparam int CW   = $clog2(CAPACITY+1);
    localparam int CMPW = (CW > pal_pkg::POS_W ? CW : pal_pkg::POS_W) + 1;
    localparam int IW   = $clog2(CAPACITY);
    localparam logic [CMPW-1:0] MY_IDX = CMPW'(CELL_IDX);

    logic [ELEMENT_WIDTH-1:0] r_elem;
    logic                     r_hit;
    logic [ELEMENT_WIDTH-1:0] r_val;
    logic [IW-1:0]            r_idx;
    logic                     w_active;

    assign w_active = MY_IDX < i_count;

    always_ff @(posedge i_clk) begin
        case (i_op)
            pal_pkg::CO_TAG_POS: begin
                r_hit <= w_active && (MY_IDX == i_sel);
                r_val <= r_elem;
                r_idx <= IW'(CELL_IDX);
            end
            pal_pkg::CO_TAG_VAL: begin
                r_hit <= w_active && (r_elem == i_key);
                r_val <= r_elem;
                r_idx <= IW'(CELL_IDX);
            end
            pal_pkg::CO_GATHER: begin
                // lower index wins: only take the far record when nothing held here
                if (!r_hit && i_far_hit) begin
                    r_hit <= 1'b1;
                    r_val <= i_far_val;
                    r_idx <= i_far_idx;
                end
            end
            pal_pkg::CO_INSERT: begin
                if (MY_IDX > i_sel) begin
                    r_elem <= i_prev;
                end else if (MY_IDX == i_sel) begin
                    r_elem <= i_key;
                end
            end
            pal_pkg::CO_REMOVE: begin
                if (MY_IDX >= i_sel) begin
                    r_elem <= i_next;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_elem = r_elem;
    assign o_hit  = r_hit;
    assign o_val  = r_val;
    assign o_idx  = r_idx;

endmodule

/* rtl/core/positional_array_list_unit.sv */
// top level of the positional array list: request control and the row of cells
//
// Requests arrive on i_req (req_type, position, value) and each one yields
// exactly one result on o_rsp (status, removed_value, found_position,
// entry_count), in request order.
// The list lives in a row of CAPACITY cells; insert and delete shift the whole
// row by one place in a single cycle, each cell taking its neighbor's entry.
// Clear, insert and unknown types raise result valid 2 cycles after the
// accepting edge (tag, apply) and take 3 cycles per request.
// Search, delete at position and delete by value raise result valid
// 2 + log2(CAPACITY) cycles after accept (8 at the default size) and take
// 3 + log2(CAPACITY) cycles per request (9): the first matching cell is found
// by a doubling gather across the row, one distance step per cycle.
// One request is in flight at a time; the next is taken the cycle after the
// result is loaded into the output register, so a result may wait there
// while the next request is accepted and worked on.
// When the receiver stalls, a finished request waits in its final step until
// the output register is free; the list is not changed before then.
// Reset empties the list (count zero), drops result valid and leaves the block
// ready for a request; stored entries are not cleared, since only entries
// below the count are ever read.
module positional_array_list_unit #(
    parameter int CAPACITY      = pal_pkg::CAPACITY_DEF,
    parameter int ELEMENT_WIDTH = pal_pkg::ELEM_W_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    pal_in_if.sink   i_req,
    pal_out_if.source o_rsp
);
    localparam int CW   = $clog2(CAPACITY+1);
    localparam int CMPW = (CW > pal_pkg::POS_W ? CW : pal_pkg::POS_W) + 1;
    localparam int IW   = $clog2(CAPACITY);
    localparam int L    = $clog2(CAPACITY);
    localparam int SW   = (L > 1) ? $clog2(L) : 1;

    pal_pkg::t_state   r_state, n_state;
    logic [SW-1:0]     r_step, n_step;
    logic [CW-1:0]     r_count, n_count;
    logic [pal_pkg::REQ_W-1:0] r_req;
    logic [pal_pkg::POS_W-1:0] r_pos;
    logic [ELEMENT_WIDTH-1:0]  r_key;

    logic                      r_out_valid;
    pal_pkg::t_status          r_out_status;
    logic [pal_pkg::VAL_W-1:0] r_out_removed;
    logic [pal_pkg::POS_W-1:0] r_out_found;
    logic [pal_pkg::CNT_W-1:0] r_out_count;

    pal_pkg::t_cell_op         w_op;
    pal_pkg::t_status          w_status;
    logic [pal_pkg::VAL_W-1:0] w_removed;
    logic [pal_pkg::POS_W-1:0] w_found;
    logic                      w_commit;
    logic                      w_slot_free;
    logic                      w_accept;
    logic [CMPW-1:0]           w_sel;
    logic [CMPW-1:0]           w_cnt_c;
    logic [CMPW-1:0]           w_pos_c;
    logic                      w_ins_ok;
    logic                      w_del_ok;
    logic                      w_full;

    logic [ELEMENT_WIDTH-1:0]  w_elem [CAPACITY];
    logic [ELEMENT_WIDTH-1:0]  w_prev [CAPACITY];
    logic [ELEMENT_WIDTH-1:0]  w_next [CAPACITY];
    logic                      w_hit  [CAPACITY];
    logic [ELEMENT_WIDTH-1:0]  w_val  [CAPACITY];
    logic [IW-1:0]             w_idx  [CAPACITY];
    logic                      w_fhit [CAPACITY];
    logic [ELEMENT_WIDTH-1:0]  w_fval [CAPACITY];
    logic [IW-1:0]             w_fidx [CAPACITY];

    assign w_accept    = i_req.valid && i_req.ready;
    assign w_slot_free = !r_out_valid || o_rsp.ready;
    assign i_req.ready = (r_state == pal_pkg::S_IDLE);

    assign w_cnt_c  = CMPW'(r_count);
    assign w_pos_c  = CMPW'(r_pos);
    assign w_ins_ok = (w_pos_c != '0) && (w_pos_c <= w_cnt_c + CMPW'(1));
    assign w_del_ok = (w_pos_c != '0) && (w_pos_c <= w_cnt_c);
    assign w_full   = (r_count == CW'(CAPACITY));

    // a delete by value shifts from the gathered index, everything else from position - 1
    assign w_sel = (r_state == pal_pkg::S_APPLY && r_req == pal_pkg::REQ_DEL_VAL) ?
                   CMPW'(w_idx[0]) : w_pos_c - CMPW'(1);

    always_comb begin
        n_state   = r_state;
        n_step    = r_step;
        n_count   = r_count;
        w_op      = pal_pkg::CO_HOLD;
        w_status  = pal_pkg::STS_DONE;
        w_removed = '0;
        w_found   = '0;
        w_commit  = 1'b0;
        case (r_state)
            pal_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_state = pal_pkg::S_TAG;
                end
            end
            pal_pkg::S_TAG: begin
                w_op   = (r_req == pal_pkg::REQ_DEL_POS) ? pal_pkg::CO_TAG_POS
                                                          : pal_pkg::CO_TAG_VAL;
                n_step = '0;
                if (r_req == pal_pkg::REQ_DEL_POS || r_req == pal_pkg::REQ_SEARCH ||
                    r_req == pal_pkg::REQ_DEL_VAL) begin
                    n_state = pal_pkg::S_GATHER;
                end else begin
                    n_state = pal_pkg::S_APPLY;
                end
            end
            pal_pkg::S_GATHER: begin
                w_op = pal_pkg::CO_GATHER;
                if (r_step == SW'(L-1)) begin
                    n_state = pal_pkg::S_APPLY;
                end else begin
                    n_step = r_step + SW'(1);
                end
            end
            pal_pkg::S_APPLY: begin
                case (r_req)
                    pal_pkg::REQ_CLEAR: begin
                        n_count = '0;
                    end
                    pal_pkg::REQ_INSERT: begin
                        if (!w_ins_ok) begin
                            w_status = pal_pkg::STS_BAD_POS;
                        end else if (w_full) begin
                            w_status = pal_pkg::STS_FULL;
                        end else begin
                            w_op    = pal_pkg::CO_INSERT;
                            n_count = r_count + CW'(1);
                        end
                    end
                    pal_pkg::REQ_DEL_POS: begin
                        if (!w_del_ok) begin
                            w_status = pal_pkg::STS_BAD_POS;
                        end else begin
                            w_op      = pal_pkg::CO_REMOVE;
                            w_removed = 32'($signed(w_val[0]));
                            n_count   = r_count - CW'(1);
                        end
                    end
                    pal_pkg::REQ_SEARCH: begin
                        if (!w_hit[0]) begin
                            w_status = pal_pkg::STS_NOT_FOUND;
                        end else begin
                            w_found = pal_pkg::POS_W'(CMPW'(w_idx[0]) + CMPW'(1));
                        end
                    end
                    pal_pkg::REQ_DEL_VAL: begin
                        if (!w_hit[0]) begin
                            w_status = pal_pkg::STS_NOT_FOUND;
                        end else begin
                            w_op      = pal_pkg::CO_REMOVE;
                            w_found   = pal_pkg::POS_W'(CMPW'(w_idx[0]) + CMPW'(1));
                            w_removed = 32'($signed(w_val[0]));
                            n_count   = r_count - CW'(1);
                        end
                    end
                    default: begin
                    end
                endcase
                // hold everything until the output register can take the result
                if (w_slot_free) begin
                    w_commit = 1'b1;
                    n_state  = pal_pkg::S_IDLE;
                end else begin
                    w_op    = pal_pkg::CO_HOLD;
                    n_count = r_count;
                end
            end
            default: begin
                n_state = pal_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pal_pkg::S_IDLE;
            r_step      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_count <= n_count;
            if (w_commit) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req <= i_req.req_type;
            r_pos <= i_req.position;
            r_key <= ELEMENT_WIDTH'($unsigned(i_req.value));
        end
        if (w_commit) begin
            r_out_status  <= w_status;
            r_out_removed <= w_removed;
            r_out_found   <= w_found;
            r_out_count   <= pal_pkg::CNT_W'(n_count);
        end
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.status         = r_out_status;
    assign o_rsp.removed_value  = r_out_removed;
    assign o_rsp.found_position = r_out_found;
    assign o_rsp.entry_count    = r_out_count;

    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        if (gi == 0) begin : g_first
            assign w_prev[gi] = '0;
        end else begin : g_mid_prev
            assign w_prev[gi] = w_elem[gi-1];
        end
        if (gi == CAPACITY-1) begin : g_last
            assign w_next[gi] = '0;
        end else begin : g_mid_next
            assign w_next[gi] = w_elem[gi+1];
        end

        // gather partner sits 2^step cells further up the row
        always_comb begin
            int j;
            w_fhit[gi] = 1'b0;
            w_fval[gi] = '0;
            w_fidx[gi] = '0;
            for (int k = 0; k < L; k++) begin
                j = gi + (1 << k);
                if (j < CAPACITY && r_step == SW'(k)) begin
                    w_fhit[gi] = w_hit[IW'(j)];
                    w_fval[gi] = w_val[IW'(j)];
                    w_fidx[gi] = w_idx[IW'(j)];
                end
            end
        end

        pal_cell #(
            .CAPACITY      (CAPACITY),
            .ELEMENT_WIDTH (ELEMENT_WIDTH),
            .CELL_IDX      (gi)
        ) u_cell (
            .i_clk     (i_clk),
            .i_op      (w_op),
            .i_key     (r_key),
            .i_sel     (w_sel),
            .i_count   (w_cnt_c),
            .i_prev    (w_prev[gi]),
            .i_next    (w_next[gi]),
            .i_far_hit (w_fhit[gi]),
            .i_far_val (w_fval[gi]),
            .i_far_idx (w_fidx[gi]),
            .o_elem    (w_elem[gi]),
            .o_hit     (w_hit[gi]),
            .o_val     (w_val[gi]),
            .o_idx     (w_idx[gi])
        );
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count beyond capacity");

    a_accept_to_tag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_state == pal_pkg::S_TAG)
        else $error("accepted request did not start tagging");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_commit && r_req == pal_pkg::REQ_INSERT && w_status == pal_pkg::STS_DONE)
        |=> r_count == $past(r_count) + CW'(1))
        else $error("insert did not grow the list by one");

    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == pal_pkg::S_GATHER |-> r_step <= SW'(L-1))
        else $error("gather step out of range");

    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_rsp.ready) |-> !w_commit)
        else $error("result overwrote a waiting result");

endmodule

/* tb/positional_array_list_unit_tb.sv */
// self-checking testbench for the positional array list unit
module positional_array_list_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pal_pkg::*;

    localparam int CAP          = CAPACITY_DEF;
    localparam int RANDOM_ITEMS = 750;
    localparam int STALL_LIMIT  = 4000;
    localparam int HOLD_CYCLES  = 300;
    localparam int TAIL_CYCLES  = 40;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        logic [REQ_W-1:0]        req_type;
        logic [POS_W-1:0]        position;
        logic signed [VAL_W-1:0] value;
    } list_request_t;

    typedef struct packed {
        logic [STS_W-1:0]        status;
        logic signed [VAL_W-1:0] removed;
        logic [POS_W-1:0]        found;
        logic [CNT_W-1:0]        count;
    } list_result_t;

    typedef logic signed [VAL_W-1:0] list_mem_t [CAP];

    logic                    i_clk        = 1'b0;
    logic                    i_rst_n      = 1'b0;
    logic                    req_valid    = 1'b0;
    logic [REQ_W-1:0]        req_type     = '0;
    logic [POS_W-1:0]        req_position = '0;
    logic signed [VAL_W-1:0] req_value    = '0;
    logic                    rsp_ready    = 1'b0;

    pal_in_if  req_if ();
    pal_out_if rsp_if ();

    assign req_if.valid    = req_valid;
    assign req_if.req_type = req_type;
    assign req_if.position = req_position;
    assign req_if.value    = req_value;
    assign rsp_if.ready    = rsp_ready;

    positional_array_list_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    always #2 i_clk = ~i_clk;

    // checker copy of the list and the copy used to shape stimulus
    list_mem_t     list_mem;
    int            list_cnt = 0;
    list_mem_t     gen_mem;
    int            gen_cnt = 0;

    list_request_t pending_reqs[$];
    list_result_t  expected_results[$];
    list_request_t next_req;
    list_result_t  want;
    list_result_t  got;
    logic          req_fire    = 1'b0;
    int            n_accepted  = 0;
    int            total_reqs  = 0;
    int            mismatches  = 0;
    int            hold_left   = 0;
    bit            hold_done   = 1'b0;
    int            quiet       = 0;

    // serves one request on a list copy, returns the result it gives
    function automatic list_result_t apply_request(ref list_mem_t mem, ref int cnt,
                                                   input list_request_t r);
        list_result_t res;
        int p;
        int idx;
        int i;
        res = '0;
        p   = int'(r.position);
        idx = CAP;
        case (r.req_type)
            REQ_CLEAR: cnt = 0;
            REQ_INSERT: begin
                if (p < 1 || p > cnt + 1) begin
                    res.status = STS_BAD_POS;
                end else if (cnt >= CAP) begin
                    res.status = STS_FULL;
                end else begin
                    for (i = cnt; i > p - 1; i--) mem[i] = mem[i - 1];
                    mem[p - 1] = r.value;
                    cnt++;
                end
            end
            REQ_DEL_POS: begin
                if (p < 1 || p > cnt) res.status = STS_BAD_POS;
                else idx = p - 1;
            end
            REQ_SEARCH, REQ_DEL_VAL: begin
                for (i = cnt - 1; i >= 0; i--) begin
                    if (mem[i] == r.value) idx = i;
                end
                if (idx == CAP) res.status = STS_NOT_FOUND;
                else res.found = POS_W'(idx + 1);
            end
            default: ;
        endcase
        // removal closes the gap by shifting the tail down
        if (idx < CAP && r.req_type != REQ_SEARCH) begin
            res.removed = mem[idx];
            for (i = idx; i < cnt - 1; i++) mem[i] = mem[i + 1];
            cnt--;
        end
        res.count = CNT_W'(cnt);
        return res;
    endfunction

    task automatic queue_request(input logic [REQ_W-1:0] t, input int p,
                                 input logic signed [VAL_W-1:0] v);
        list_request_t r;
        r.req_type = t;
        r.position = POS_W'(p);
        r.value    = v;
        void'(apply_request(gen_mem, gen_cnt, r));
        pending_reqs.push_back(r);
    endtask

    function automatic logic signed [VAL_W-1:0] pick_value();
        logic signed [VAL_W-1:0] v;
        v = $urandom;
        case ($urandom_range(0, 7))
            0, 1: v = VAL_W'($urandom_range(0, 8)) - 4;   // small pool, many duplicates
            2: v = {1'b1, {(VAL_W-1){1'b0}}};
            3: v = {1'b0, {(VAL_W-1){1'b1}}};
            4: v = '0;
            5: v = '1;
            default: ;
        endcase
        return v;
    endfunction

    function automatic logic signed [VAL_W-1:0] pick_key();
        if (gen_cnt > 0 && $urandom_range(0, 9) < 7) return gen_mem[$urandom_range(0, gen_cnt - 1)];
        return pick_value();
    endfunction

    function automatic int phase_of();
        if (total_reqs == 0) return 0;
        return (n_accepted * 3) / total_reqs;
    endfunction

    // stimulus, reset and end of run
    initial begin
        int n_rand;
        int roll;
        int len;
        int k;

        queue_request(REQ_CLEAR, 0, '0);
        queue_request(REQ_DEL_POS, 1, '0);
        queue_request(REQ_SEARCH, 0, '0);
        queue_request(REQ_DEL_VAL, 0, '1);
        queue_request(REQ_INSERT, 0, 32'sd7);
        queue_request(REQ_INSERT, 2, 32'sd7);
        queue_request(REQ_INSERT, 1, {1'b1, {(VAL_W-1){1'b0}}});
        queue_request(REQ_INSERT, 2, {1'b0, {(VAL_W-1){1'b1}}});
        queue_request(REQ_INSERT, 1, '0);
        queue_request(REQ_INSERT, 2, '1);
        queue_request(REQ_INSERT, 127, 32'sd3);
        queue_request(REQ_SEARCH, 0, {1'b0, {(VAL_W-1){1'b1}}});
        queue_request(REQ_SEARCH, 127, 32'sd5);
        queue_request(REQ_INSERT, 5, '1);
        queue_request(REQ_SEARCH, 0, '1);
        queue_request(REQ_DEL_VAL, 0, '1);
        queue_request(REQ_DEL_POS, 4, '0);
        queue_request(REQ_DEL_POS, 5, '0);
        queue_request(REQ_DEL_POS, 0, '0);
        queue_request(3'd5, 127, $urandom);
        queue_request(3'd6, 64, $urandom);
        queue_request(3'd7, 1, '1);
        queue_request(REQ_DEL_POS, 1, '0);
        queue_request(REQ_CLEAR, 127, '1);

        n_rand = 0;
        while (n_rand < RANDOM_ITEMS) begin
            roll = $urandom_range(0, 99);
            if (roll < 5) begin
                // load: clear then appends, now and then past a full list
                len = ($urandom_range(0, 7) == 0) ? CAP + $urandom_range(1, 3)
                                                  : $urandom_range(1, 12);
                queue_request(REQ_CLEAR, $urandom_range(0, 127), $urandom);
                for (k = 0; k < len; k++) queue_request(REQ_INSERT, gen_cnt + 1, pick_value());
                n_rand += len;
            end else if (roll < 36) begin
                queue_request(REQ_INSERT, $urandom_range(1, gen_cnt + 1), pick_value());
            end else if (roll < 52) begin
                if (gen_cnt == 0) queue_request(REQ_INSERT, 1, pick_value());
                else queue_request(REQ_DEL_POS, $urandom_range(1, gen_cnt), $urandom);
            end else if (roll < 68) begin
                queue_request(REQ_SEARCH, $urandom_range(0, 127), pick_key());
            end else if (roll < 80) begin
                queue_request(REQ_DEL_VAL, $urandom_range(0, 127), pick_key());
            end else if (roll < 89) begin
                queue_request($urandom_range(0, 7), $urandom_range(0, 127), $urandom);
            end else if (roll < 95) begin
                queue_request(REQ_INSERT, ($urandom_range(0, 3) == 0) ? 0
                              : $urandom_range(gen_cnt + 2, 127), pick_value());
            end else begin
                queue_request(REQ_DEL_POS, ($urandom_range(0, 3) == 0) ? 0
                              : $urandom_range(gen_cnt + 1, 127), $urandom);
            end
            n_rand++;
        end
        total_reqs = pending_reqs.size();

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_reqs.size() != 0 || req_valid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // request driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            req_valid <= 1'b0;
        end else if (!req_valid || req_fire) begin
            if (pending_reqs.size() != 0 &&
                $urandom_range(0, 99) >= (phase_of() == 0 ? 19 : phase_of() == 1 ? 82 : 0)) begin
                next_req      = pending_reqs.pop_front();
                req_valid    <= 1'b1;
                req_type     <= next_req.req_type;
                req_position <= next_req.position;
                req_value    <= next_req.value;
            end else begin
                req_valid <= 1'b0;
            end
        end
    end

    // result receiver, with one long hold-off to back up the block
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_ready <= 1'b0;
        end else if (!hold_done && phase_of() == 2) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            rsp_ready <= 1'b0;
        end else begin
            rsp_ready <= $urandom_range(0, 99) >= (phase_of() == 0 ? 82 : phase_of() == 1 ? 19 : 0);
        end
    end

    // monitor: predict on each accepted request, check each result
    always @(posedge i_clk) begin
        req_fire <= i_rst_n && req_valid && req_if.ready;
        if (i_rst_n && rsp_if.valid && rsp_ready) begin
            got = {rsp_if.status, rsp_if.removed_value, rsp_if.found_position,
                   rsp_if.entry_count};
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result: status %0d removed %0d found %0d count %0d",
                             got.status, got.removed, got.found, got.count);
            end else begin
                want = expected_results.pop_front();
                if (got.status !== want.status || got.removed !== want.removed ||
                    got.found !== want.found || got.count !== want.count) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display({"result mismatch: expected status %0d removed %0d found %0d",
                                  " count %0d, got status %0d removed %0d found %0d count %0d"},
                                 want.status, want.removed, want.found, want.count,
                                 got.status, got.removed, got.found, got.count);
                end
            end
        end
        if (i_rst_n && req_valid && req_if.ready) begin
            expected_results.push_back(apply_request(list_mem, list_cnt,
                                       {req_type, req_position, req_value}));
            n_accepted++;
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge i_clk) begin
        if ((req_valid && req_if.ready) || (rsp_if.valid && rsp_ready)) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

endmodule
